// File: src/alps_pkg.sv
package alps_pkg;

   localparam int STORE_DEPTH_DEF = 128;

   localparam int TEMPO_W = 12;
   localparam logic [TEMPO_W-1:0] TEMPO_RESET = 12'd250;

   localparam logic [1:0] INSTR_TEMPO = 2'd1;
   localparam logic [1:0] INSTR_START = 2'd3;  // other id: start program
   localparam logic [1:0] INSTR_RESTART = 2'd3;  // own id: restart recording

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [4:0] LED_UPPER_OFF = 5'b11111;
   localparam logic [2:0] ENTRY0_RESET = 3'b111;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COPY,
      S_EMIT
   } state_type;

endpackage

// File: src/alps_ram.sv
module alps_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = alps_pkg::STORE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/addressed_led_pattern_sequencer.sv
// Addressed LED pattern sequencer.
// Input channel (req_): one transaction is either a received serial byte
// (req_action = 0, byte on req_rx_byte) or a millisecond tick (req_action = 1).
// Result channel (rsp_): an active-low LED byte, at most one per tick.
// The first byte after reset sets the own id; bytes for the own id record
// a pattern, bytes for other ids set the tempo or start playback.
// Timing: a serial byte causes no stall, except a start command with a
// non-empty record, which copies the record RAM into the play RAM: the
// copy index counter addresses the record reads, and a registered copy of
// it the play RAM writes. A tick that emits does one play RAM read, then the
// output register load in S_EMIT; other ticks need no further state.
// req_ready is low while a copy runs or a result waits for the output
// register. If the receiver stalls, the result holds in rsp_ and the block
// stays busy until that register frees up.
// Reset empties the output register and returns all counters to their
// reset values; play entry 0 reads as all ones until a program replaces it.
// No clearing pass is needed.
module addressed_led_pattern_sequencer #(
   parameter int STORE_DEPTH = alps_pkg::STORE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_led_pattern
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int TW = alps_pkg::TEMPO_W;

   alps_pkg::state_type state_ff, state_in;

   logic [2:0]    own_id_ff, own_id_in;
   logic          id_known_ff, id_known_in;
   logic [AW-1:0] rec_pos_ff, rec_pos_in;
   logic [CW-1:0] rec_cnt_ff, rec_cnt_in;
   logic [CW-1:0] play_len_ff, play_len_in;
   logic [CW-1:0] play_pos_ff, play_pos_in;
   logic [TW-1:0] tempo_ff, tempo_in;
   logic [TW-1:0] ticks_ff, ticks_in;
   logic          entry0_ff, entry0_in;
   logic          rd_zero_ff, rd_zero_in;
   logic [CW-1:0] cp_idx_ff, cp_idx_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_led_ff, rsp_led_in;

   logic          accept;
   logic [2:0]    rx_id;
   logic [2:0]    rx_payload;
   logic [1:0]    rx_instr;
   logic [TW-1:0] rx_tempo;
   logic [CW-1:0] pos_eff;

   logic          rec_we;
   logic          rec_re;
   logic [2:0]    rec_rd_data;
   logic          play_re;
   logic [2:0]    play_rd_data;

   assign req_ready = (state_ff == alps_pkg::S_IDLE);
   assign accept = req_valid && req_ready;
   assign rx_id = req_rx_byte[7:5];
   assign rx_payload = req_rx_byte[4:2];
   assign rx_instr = req_rx_byte[1:0];
   // (byte & 0xFC) * 10 as shifts: x*8 + x*2
   assign rx_tempo = ({4'b0, req_rx_byte[7:2], 2'b00} << 3)
                   + ({4'b0, req_rx_byte[7:2], 2'b00} << 1);
   assign pos_eff = (play_pos_ff >= play_len_ff || play_pos_ff >= CW'(STORE_DEPTH))
                  ? '0 : play_pos_ff;

   always_comb begin
      state_in = state_ff;
      own_id_in = own_id_ff;
      id_known_in = id_known_ff;
      rec_pos_in = rec_pos_ff;
      rec_cnt_in = rec_cnt_ff;
      play_len_in = play_len_ff;
      play_pos_in = play_pos_ff;
      tempo_in = tempo_ff;
      ticks_in = ticks_ff;
      entry0_in = entry0_ff;
      rd_zero_in = rd_zero_ff;
      cp_idx_in = cp_idx_ff;
      wr_pend_in = 1'b0;
      wr_idx_in = wr_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_led_in = rsp_led_ff;
      rec_we = 1'b0;
      rec_re = 1'b0;
      play_re = 1'b0;

      case (state_ff)
         alps_pkg::S_IDLE: begin
            if (accept && req_action == alps_pkg::ACTION_BYTE) begin
               if (!id_known_ff) begin
                  own_id_in = rx_id;
                  id_known_in = 1'b1;
               end else if (rx_id == own_id_ff) begin
                  if (rx_instr == alps_pkg::INSTR_RESTART) begin
                     rec_pos_in = '0;
                     rec_cnt_in = '0;
                  end else begin
                     rec_we = 1'b1;
                     rec_pos_in = (rec_pos_ff == AW'(STORE_DEPTH - 1))
                                ? '0 : rec_pos_ff + AW'(1);
                     if (rec_cnt_ff != CW'(STORE_DEPTH)) begin
                        rec_cnt_in = rec_cnt_ff + CW'(1);
                     end
                  end
               end else if (rx_instr == alps_pkg::INSTR_TEMPO) begin
                  tempo_in = rx_tempo;
                  ticks_in = '0;
               end else if (rx_instr == alps_pkg::INSTR_START) begin
                  play_len_in = rec_cnt_ff;
                  play_pos_in = '0;
                  cp_idx_in = '0;
                  if (rec_cnt_ff != '0) begin
                     entry0_in = 1'b0;
                     state_in = alps_pkg::S_COPY;
                  end
               end
            end else if (accept && id_known_ff) begin
               if (ticks_ff != '0) begin
                  ticks_in = ticks_ff - TW'(1);
               end else begin
                  play_re = 1'b1;
                  rd_zero_in = (pos_eff == '0);
                  play_pos_in = pos_eff + CW'(1);
                  ticks_in = (tempo_ff != '0) ? tempo_ff - TW'(1) : '0;
                  state_in = alps_pkg::S_EMIT;
               end
            end
         end

         alps_pkg::S_COPY: begin
            // read one record entry a cycle, write it to play RAM the next
            if (cp_idx_ff < play_len_ff) begin
               rec_re = 1'b1;
               wr_pend_in = 1'b1;
               wr_idx_in = cp_idx_ff[AW-1:0];
               cp_idx_in = cp_idx_ff + CW'(1);
            end else if (!wr_pend_ff) begin
               state_in = alps_pkg::S_IDLE;
            end
         end

         alps_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_led_in = {alps_pkg::LED_UPPER_OFF,
                             (rd_zero_ff && entry0_ff) ? alps_pkg::ENTRY0_RESET
                                                       : play_rd_data};
               state_in = alps_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = alps_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alps_pkg::S_IDLE;
         own_id_ff <= '0;
         id_known_ff <= 1'b0;
         rec_pos_ff <= '0;
         rec_cnt_ff <= '0;
         play_len_ff <= CW'(1);
         play_pos_ff <= '0;
         tempo_ff <= alps_pkg::TEMPO_RESET;
         ticks_ff <= '0;
         entry0_ff <= 1'b1;
         cp_idx_ff <= '0;
         wr_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         own_id_ff <= own_id_in;
         id_known_ff <= id_known_in;
         rec_pos_ff <= rec_pos_in;
         rec_cnt_ff <= rec_cnt_in;
         play_len_ff <= play_len_in;
         play_pos_ff <= play_pos_in;
         tempo_ff <= tempo_in;
         ticks_ff <= ticks_in;
         entry0_ff <= entry0_in;
         cp_idx_ff <= cp_idx_in;
         wr_pend_ff <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_zero_ff <= rd_zero_in;
      wr_idx_ff <= wr_idx_in;
      rsp_led_ff <= rsp_led_in;
   end

   alps_ram #(
      .WIDTH(3),
      .DEPTH(STORE_DEPTH)
   ) u_rec_ram (
      .clock  (clock),
      .wr_en  (rec_we),
      .wr_addr(rec_pos_ff),
      .wr_data(~rx_payload),
      .rd_en  (rec_re),
      .rd_addr(cp_idx_ff[AW-1:0]),
      .rd_data(rec_rd_data)
   );

   alps_ram #(
      .WIDTH(3),
      .DEPTH(STORE_DEPTH)
   ) u_play_ram (
      .clock  (clock),
      .wr_en  (wr_pend_ff),
      .wr_addr(wr_idx_ff),
      .wr_data(rec_rd_data),
      .rd_en  (play_re),
      .rd_addr(pos_eff[AW-1:0]),
      .rd_data(play_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_led_pattern = rsp_led_ff;

endmodule

// File: src/alps_checker.sv
module alps_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_action,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_led_pattern
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_led_pattern))
      else $error("stalled result changed");

   // upper five LEDs stay off
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_led_pattern[7:3] == alps_pkg::LED_UPPER_OFF)
      else $error("upper LED bits not off");

   // a serial byte never produces a result right behind it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == alps_pkg::ACTION_BYTE
      |=> !$rose(rsp_valid))
      else $error("result after serial byte");

   // results only come from ticks: a new result follows a tick transaction
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result without pending tick");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind addressed_led_pattern_sequencer alps_checker u_alps_checker (.*);

// File: verif/tb_addressed_led_pattern_sequencer.sv
module tb_addressed_led_pattern_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = alps_pkg::STORE_DEPTH_DEF;
   localparam int PW = $clog2(DEPTH);
   localparam int TW = alps_pkg::TEMPO_W;
   localparam int RANDOM_ITEMS = 830;
   localparam int HOLD_CYCLES = 250;

   // instructions that bytes for another id leave without effect
   localparam logic [1:0] INSTR_NOP_A = 2'd0;
   localparam logic [1:0] INSTR_NOP_B = 2'd2;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_action;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_led_pattern;

   addressed_led_pattern_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_led_pattern(rsp_led_pattern)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // sequencer state as the testbench predicts it
   logic [2:0]    own_id;
   logic          id_known;
   logic [2:0]    rec_mem [DEPTH];
   logic [PW-1:0] rec_pos;
   logic [PW:0]   rec_count;
   logic [2:0]    play_mem [DEPTH];
   logic [PW:0]   play_len;
   logic [PW:0]   play_pos;
   logic [TW-1:0] tempo_ms;
   logic [TW-1:0] ticks_left;

   logic [7:0] led_queue [$];

   int   err_count = 0;
   int   items_sent = 0;
   int   burst_left = 0;
   bit   noise_on = 0;
   bit   hold_request = 0;
   logic [2:0] my_id;

   task automatic reset_sequencer_model();
      own_id = '0;
      id_known = 1'b0;
      rec_pos = '0;
      rec_count = '0;
      for (int j = 0; j < DEPTH; j++) play_mem[j] = '0;
      play_mem[0] = alps_pkg::ENTRY0_RESET;
      play_len = (PW+1)'(1);
      play_pos = '0;
      tempo_ms = alps_pkg::TEMPO_RESET;
      ticks_left = '0;
   endtask

   task automatic predict_led(input logic act, input logic [7:0] b);
      logic [2:0] id;
      logic [2:0] pay;
      logic [1:0] ins;
      id = b[7:5];
      pay = b[4:2];
      ins = b[1:0];
      if (act == alps_pkg::ACTION_BYTE) begin
         if (!id_known) begin
            own_id = id;
            id_known = 1'b1;
         end else if (id == own_id) begin
            if (ins == alps_pkg::INSTR_RESTART) begin
               rec_pos = '0;
               rec_count = '0;
            end else begin
               rec_mem[rec_pos] = ~pay;
               rec_pos = (int'(rec_pos) == DEPTH - 1) ? '0 : rec_pos + 1'b1;
               if (int'(rec_count) < DEPTH) rec_count = rec_count + 1'b1;
            end
         end else if (ins == alps_pkg::INSTR_TEMPO) begin
            tempo_ms = TW'(int'({b[7:2], 2'b00}) * 10);
            ticks_left = '0;
         end else if (ins == alps_pkg::INSTR_START) begin
            for (int j = 0; j < int'(rec_count); j++) play_mem[j] = rec_mem[j];
            play_len = rec_count;
            play_pos = '0;
         end
      end else if (id_known) begin
         if (ticks_left != 0) begin
            ticks_left = ticks_left - 1'b1;
         end else begin
            if (play_pos >= play_len || int'(play_pos) >= DEPTH) play_pos = '0;
            led_queue.push_back({alps_pkg::LED_UPPER_OFF, play_mem[play_pos]});
            play_pos = play_pos + 1'b1;
            ticks_left = (tempo_ms != 0) ? tempo_ms - 1'b1 : '0;
         end
      end
   endtask

   // one transaction on the request side, bursts separated by random gaps
   task automatic send_item(input logic act, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_led(act, b);
      items_sent++;
      burst_left--;
   endtask

   // program item, with a random stray transaction in front now and then
   task automatic send_mixed(input logic act, input logic [7:0] b);
      if (noise_on && $urandom_range(0, 7) == 0)
         send_item(1'($urandom), 8'($urandom));
      send_item(act, b);
   endtask

   function automatic logic [2:0] other_id();
      logic [2:0] id;
      id = 3'($urandom);
      while (id == my_id) id = 3'($urandom);
      return id;
   endfunction

   task automatic send_tempo(input logic [2:0] pay);
      send_mixed(alps_pkg::ACTION_BYTE, {3'd0, pay, alps_pkg::INSTR_TEMPO});
   endtask

   task automatic record_and_play(input int n_appends, input logic [2:0] tempo_pay,
                                  input int n_ticks, input bit restart,
                                  input bit tempo_first);
      logic [1:0] ins;
      if (restart)
         send_mixed(alps_pkg::ACTION_BYTE, {my_id, 3'($urandom), alps_pkg::INSTR_RESTART});
      for (int j = 0; j < n_appends; j++) begin
         ins = alps_pkg::INSTR_RESTART;
         while (ins == alps_pkg::INSTR_RESTART) ins = 2'($urandom);
         send_mixed(alps_pkg::ACTION_BYTE, {my_id, 3'($urandom), ins});
      end
      if (tempo_first) send_tempo(tempo_pay);
      send_mixed(alps_pkg::ACTION_BYTE, {other_id(), 3'($urandom), alps_pkg::INSTR_START});
      if (!tempo_first) send_tempo(tempo_pay);
      repeat (n_ticks) send_mixed(alps_pkg::ACTION_TICK, 8'($urandom));
   endtask

   task automatic test_ticks_before_id();
      repeat (2) send_item(alps_pkg::ACTION_TICK, 8'($urandom));
   endtask

   task automatic test_id_latch();
      // id 0 and id 7 must stay free for the slowest and fastest tempo
      my_id = 3'($urandom_range(1, 6));
      send_item(alps_pkg::ACTION_BYTE, {my_id, 3'($urandom), 2'($urandom)});
   endtask

   task automatic test_record_playback();
      // reset program: entry 0 all ones, first tick emits, next one waits
      send_item(alps_pkg::ACTION_TICK, 8'h00);
      send_item(alps_pkg::ACTION_TICK, 8'hFF);
      send_item(alps_pkg::ACTION_BYTE, {my_id, 3'd0, alps_pkg::INSTR_RESTART});
      send_item(alps_pkg::ACTION_BYTE, {my_id, 3'd0, INSTR_NOP_A});
      send_item(alps_pkg::ACTION_BYTE, {my_id, 3'd7, alps_pkg::INSTR_TEMPO});
      send_item(alps_pkg::ACTION_BYTE, {my_id, 3'd5, INSTR_NOP_B});
      send_item(alps_pkg::ACTION_BYTE, {other_id(), 3'd7, INSTR_NOP_A});
      send_item(alps_pkg::ACTION_BYTE, {other_id(), 3'd7, INSTR_NOP_B});
      send_item(alps_pkg::ACTION_BYTE, {other_id(), 3'd0, alps_pkg::INSTR_START});
      send_item(alps_pkg::ACTION_BYTE, {3'd0, 3'd0, alps_pkg::INSTR_TEMPO});
      repeat (5) send_item(alps_pkg::ACTION_TICK, 8'($urandom));
      // slowest tempo: the tick right after the change still emits
      send_item(alps_pkg::ACTION_BYTE, {3'd7, 3'd7, alps_pkg::INSTR_TEMPO});
      send_item(alps_pkg::ACTION_TICK, 8'($urandom));
      send_item(alps_pkg::ACTION_TICK, 8'($urandom));
      // empty program keeps showing entry 0
      send_item(alps_pkg::ACTION_BYTE, {my_id, 3'd7, alps_pkg::INSTR_RESTART});
      send_item(alps_pkg::ACTION_BYTE, {other_id(), 3'd7, alps_pkg::INSTR_START});
      send_item(alps_pkg::ACTION_BYTE, {3'd0, 3'd0, alps_pkg::INSTR_TEMPO});
      repeat (3) send_item(alps_pkg::ACTION_TICK, 8'($urandom));
   endtask

   task automatic test_store_wrap();
      int n;
      n = DEPTH + $urandom_range(1, 10);
      record_and_play(n, 3'd0, DEPTH + 6, 1'b1, 1'b1);
   endtask

   task automatic test_backpressure();
      send_tempo(3'd0);
      hold_request = 1'b1;
      burst_left = 40;
      repeat (16) send_item(alps_pkg::ACTION_TICK, 8'($urandom));
   endtask

   task automatic test_random_programs();
      int first;
      int n;
      int ticks;
      int pick;
      logic [2:0] tpay;
      first = items_sent;
      noise_on = 1'b1;
      while (items_sent - first < RANDOM_ITEMS) begin
         n = ($urandom_range(0, 24) == 0) ? $urandom_range(DEPTH - 8, DEPTH + 12)
                                          : $urandom_range(0, 12);
         pick = $urandom_range(0, 9);
         tpay = (pick < 6) ? 3'd0 : (pick < 9) ? 3'd1 : 3'($urandom_range(2, 3));
         ticks = (tpay == 0) ? $urandom_range(1, 2 * n + 6) : $urandom_range(10, 100);
         record_and_play(n, tpay, ticks, $urandom_range(0, 4) != 0, $urandom_range(0, 2) != 0);
      end
      noise_on = 1'b0;
   endtask

   // receiver: random stall pattern plus one long hold on request
   initial begin
      int mode;
      int mode_left;
      int stall_left;
      int hold_left;
      rsp_ready = 1'b0;
      mode = 0;
      mode_left = 0;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (stall_left == 0) begin
               case (mode)
                  1: if ($urandom_range(0, 1) == 0) stall_left = 1;
                  2: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 20);
                  default: ;
               endcase
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // result check against the oldest predicted LED byte
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (led_queue.size() == 0) begin
            err_count++;
            $display("%0t: unexpected transaction, expected none, actual led_pattern %02h",
                     $time, rsp_led_pattern);
         end else begin
            want = led_queue.pop_front();
            if (rsp_led_pattern !== want) begin
               err_count++;
               $display("%0t: led_pattern mismatch, expected %02h, actual %02h",
                        $time, want, rsp_led_pattern);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = alps_pkg::ACTION_BYTE;
      req_rx_byte = 8'h00;
      reset_sequencer_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_ticks_before_id();
      test_id_latch();
      test_record_playback();
      test_store_wrap();
      test_backpressure();
      test_random_programs();
      req_valid <= 1'b0;
      while (led_queue.size() != 0) @(posedge clock);
      // a start command can still be copying after the last result
      repeat (DEPTH + 50) @(posedge clock);
      if (led_queue.size() != 0) err_count++;
      if (err_count == 0) begin
         $display("Verification passed");
      end else begin
         if (led_queue.size() != 0)
            $display("%0t: %0d expected transactions never arrived", $time, led_queue.size());
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("%0t: timeout, %0d expected transactions outstanding", $time, led_queue.size());
      $display("Verification failed");
      $finish;
   end

endmodule
